/* rtl/rwl_pkg.sv */
// ----------------------------------------------------------------------------
// rwl_pkg
// shared types, constants and helpers of the fifo reader-writer lock manager
// ----------------------------------------------------------------------------
package rwl_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_READERS = 255;
	localparam int MAX_RESULTS = 17;

	localparam int ID_W    = 8;
	localparam int IDX_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int RD_W    = $clog2(MAX_READERS + 1);
	localparam int GRANT_W = $clog2(MAX_RESULTS);

	// request codes
	localparam logic [1:0] MODE_READ   = 2'd0;
	localparam logic [1:0] MODE_WRITE  = 2'd1;
	localparam logic [1:0] MODE_UNLOCK = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	typedef enum logic [2:0] {
		ST_GRANTED      = 3'd0,
		ST_QUEUED       = 3'd1,
		ST_RELEASED     = 3'd2,
		ST_WAITER       = 3'd3,
		ST_UNLOCK_FREE  = 3'd4,
		ST_WRONG_WRITER = 3'd5,
		ST_QUEUE_FULL   = 3'd6,
		ST_READERS_FULL = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		LK_FREE  = 2'd0,
		LK_READ  = 2'd1,
		LK_WRITE = 2'd2
	} lock_t;

	typedef logic [IDX_W-1:0] ptr_t;

	// one waiter as held in the queue memory
	typedef struct packed {
		logic            is_write;
		logic [ID_W-1:0] id;
	} entry_t;

	typedef struct packed {
		logic   we;
		ptr_t   waddr;
		entry_t wdata;
		ptr_t   raddr;
	} ram_req_t;

	function automatic ptr_t ring_next(input ptr_t idx);
		ptr_t nxt;
		nxt = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
		return nxt;
	endfunction

endpackage

/* rtl/fifo_reader_writer_lock.sv */
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock
// fair reader-writer lock manager with a fifo of waiters kept in a ram
// ----------------------------------------------------------------------------
// a lock request or an unlock that wakes nobody gives its word in the cycle
//   after acceptance and busy stays low, so one request per cycle
// an unlock that frees the lock with k waiters granted gives k+1 words, the
//   first from the drain state that the unlock registers, then one per cycle,
//   paced by the registered read of the waiter ram
// reset: lock free, no readers, queue empty; waiter ram is not cleared
module fifo_reader_writer_lock (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [rwl_pkg::ID_W-1:0] requester_id,
	output logic                    result_valid,
	output logic [2:0]              status,
	output logic [rwl_pkg::ID_W-1:0] agent_id,
	output logic                    write_grant,
	output logic                    last
);
	import rwl_pkg::*;

	ram_req_t ram_req;
	entry_t   ram_rdata;

	rwl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.mode         (mode),
		.requester_id (requester_id),
		.busy         (busy),
		.result_valid (result_valid),
		.status       (status),
		.agent_id     (agent_id),
		.write_grant  (write_grant),
		.last         (last),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata)
	);

	rwl_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_waiters (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/rwl_ram.sv */
// ----------------------------------------------------------------------------
// rwl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module rwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/rwl_ctrl.sv */
// ----------------------------------------------------------------------------
// rwl_ctrl
// lock state, queue pointers and the grant sequencer of the lock manager
// ----------------------------------------------------------------------------
module rwl_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              mode,
	input  logic [rwl_pkg::ID_W-1:0] requester_id,
	output logic                    busy,
	output logic                    result_valid,
	output logic [2:0]              status,
	output logic [rwl_pkg::ID_W-1:0] agent_id,
	output logic                    write_grant,
	output logic                    last,
	output rwl_pkg::ram_req_t       ram_req,
	input  rwl_pkg::entry_t         ram_rdata
);
	import rwl_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_DRAIN
	} state_t;

	state_t            state_q;
	lock_t             lock_q;
	logic [RD_W-1:0]   readers_q;
	logic [ID_W-1:0]   owner_q;
	ptr_t              head_q;
	ptr_t              tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [GRANT_W-1:0] grants_q;
	logic              wr_done_q;

	// result waiting to go out while the next waiter is looked at
	status_t           held_st_q;
	logic [ID_W-1:0]   held_id_q;
	logic              held_wr_q;

	logic              valid_q;
	status_t           st_q;
	logic [ID_W-1:0]   id_q;
	logic              wr_q;
	logic              last_q;

	logic              accept;
	logic              must_wait;
	logic              q_full;
	logic              enq_ok;
	logic              can_grant;
	logic [RD_W-1:0]   readers_dec;

	assign accept      = start && (state_q == S_IDLE);
	assign q_full      = (count_q >= CNT_W'(QUEUE_DEPTH));
	assign readers_dec = (readers_q != '0) ? readers_q - 1'b1 : '0;

	always_comb begin
		must_wait = 1'b0;
		case (mode)
			MODE_READ:  must_wait = !(lock_q == LK_FREE) &&
				!(lock_q == LK_READ && count_q == '0);
			MODE_WRITE: must_wait = (lock_q != LK_FREE);
			default:    must_wait = 1'b0;
		endcase
	end

	assign enq_ok = accept && must_wait && !q_full;

	// head waiter may be granted: a writer only once the readers are gone
	assign can_grant = (count_q != '0) && (grants_q < GRANT_W'(MAX_RESULTS - 1)) &&
		!wr_done_q &&
		(ram_rdata.is_write ? (lock_q != LK_READ) : (readers_q < RD_W'(MAX_READERS)));

	always_comb begin
		ram_req.we             = enq_ok;
		ram_req.waddr          = tail_q;
		ram_req.wdata.is_write = (mode == MODE_WRITE);
		ram_req.wdata.id       = requester_id;
		ram_req.raddr          = (state_q == S_DRAIN) ? ring_next(head_q) : head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lock_q    <= LK_FREE;
			readers_q <= '0;
			owner_q   <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			grants_q  <= '0;
			wr_done_q <= 1'b0;
			held_st_q <= ST_GRANTED;
			held_id_q <= '0;
			held_wr_q <= 1'b0;
			valid_q   <= 1'b0;
			st_q      <= ST_GRANTED;
			id_q      <= '0;
			wr_q      <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					valid_q <= 1'b0;
					id_q    <= requester_id;
					wr_q    <= 1'b0;
					last_q  <= 1'b1;
					if (accept && mode != MODE_NONE) begin
						valid_q <= 1'b1;
						if (must_wait) begin
							if (q_full) begin
								st_q <= ST_QUEUE_FULL;
							end else begin
								st_q    <= ST_QUEUED;
								wr_q    <= (mode == MODE_WRITE);
								tail_q  <= ring_next(tail_q);
								count_q <= count_q + 1'b1;
							end
						end else begin
							unique case (mode)
								MODE_READ: begin
									if (lock_q == LK_FREE) begin
										lock_q    <= LK_READ;
										readers_q <= RD_W'(1);
										st_q      <= ST_GRANTED;
									end else if (readers_q >= RD_W'(MAX_READERS)) begin
										st_q <= ST_READERS_FULL;
									end else begin
										readers_q <= readers_q + 1'b1;
										st_q      <= ST_GRANTED;
									end
								end
								MODE_WRITE: begin
									lock_q  <= LK_WRITE;
									owner_q <= requester_id;
									st_q    <= ST_GRANTED;
									wr_q    <= 1'b1;
								end
								default: begin
									// unlock
									st_q <= ST_RELEASED;
									if (lock_q == LK_FREE) begin
										st_q <= ST_UNLOCK_FREE;
									end else if (lock_q == LK_WRITE &&
										requester_id != owner_q) begin
										st_q <= ST_WRONG_WRITER;
									end else if (lock_q == LK_WRITE || readers_dec == '0) begin
										lock_q    <= LK_FREE;
										owner_q   <= '0;
										readers_q <= '0;
										// at least one waiter is always grantable
										if (count_q != '0) begin
											valid_q   <= 1'b0;
											held_st_q <= ST_RELEASED;
											held_id_q <= requester_id;
											held_wr_q <= 1'b0;
											grants_q  <= '0;
											wr_done_q <= 1'b0;
											state_q   <= S_DRAIN;
										end
									end else begin
										readers_q <= readers_dec;
									end
								end
							endcase
						end
					end
				end
				S_DRAIN: begin
					valid_q <= 1'b1;
					st_q    <= held_st_q;
					id_q    <= held_id_q;
					wr_q    <= held_wr_q;
					last_q  <= !can_grant;
					if (can_grant) begin
						held_st_q <= ST_WAITER;
						held_id_q <= ram_rdata.id;
						held_wr_q <= ram_rdata.is_write;
						head_q    <= ring_next(head_q);
						count_q   <= count_q - 1'b1;
						grants_q  <= grants_q + 1'b1;
						if (ram_rdata.is_write) begin
							lock_q    <= LK_WRITE;
							owner_q   <= ram_rdata.id;
							wr_done_q <= 1'b1;
						end else begin
							lock_q    <= LK_READ;
							readers_q <= readers_q + 1'b1;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = valid_q;
	assign status       = st_q;
	assign agent_id     = id_q;
	assign write_grant  = wr_q;
	assign last         = last_q;

endmodule

/* rtl/rwl_checker.sv */
// ----------------------------------------------------------------------------
// rwl_checker
// port-level checks of the lock manager, bound to the top level
// ----------------------------------------------------------------------------
module rwl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       result_valid,
	input logic [2:0] status,
	input logic       last
);
	import rwl_pkg::*;

	// a lock request is answered next cycle with a single word
	a_req_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == MODE_READ || mode == MODE_WRITE)
		|=> result_valid && last && !busy)
		else $error("lock request not answered by one word");

	a_none_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_NONE |=> !result_valid && !busy)
		else $error("unused mode gave a word");

	// words of one item come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid)
		else $error("gap inside the words of one item");

	a_waiter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_WAITER |-> $past(busy))
		else $error("waiter granted outside a grant run");

endmodule

bind fifo_reader_writer_lock rwl_checker u_rwl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.mode         (mode),
	.result_valid (result_valid),
	.status       (status),
	.last         (last)
);

/* tb/sv/tb_fifo_reader_writer_lock.sv */
// ----------------------------------------------------------------------------
// tb_fifo_reader_writer_lock
// self-checking bench for the reader-writer lock manager: a queued driver
// sends lock and unlock requests with random gaps, a behavioural lock model
// predicts every word, and a monitor compares each word as it comes out
// ----------------------------------------------------------------------------
module tb_fifo_reader_writer_lock;

	timeunit 1ns;
	timeprecision 1ps;

	import rwl_pkg::*;

	typedef struct {
		logic [1:0]      md;
		logic [ID_W-1:0] who;
		int              gap;
		bit              settle;
	} lock_request_t;

	typedef struct {
		status_t         st;
		logic [ID_W-1:0] agent;
		logic            wr;
		logic            fin;
	} lock_reply_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	logic [1:0]      mode = MODE_NONE;
	logic [ID_W-1:0] requester_id = '0;
	logic            result_valid;
	logic [2:0]      status;
	logic [ID_W-1:0] agent_id;
	logic            write_grant;
	logic            last;

	fifo_reader_writer_lock dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.requester_id (requester_id),
		.result_valid (result_valid),
		.status       (status),
		.agent_id     (agent_id),
		.write_grant  (write_grant),
		.last         (last)
	);

	always #6 clk = ~clk;

	lock_request_t   lock_requests[$];
	lock_reply_t     lock_replies[$];
	int              requests_total;
	int              requests_taken = 0;
	int              words_checked = 0;
	int              faults = 0;
	int              status_hits[8];
	int              hold_off = 0;
	bit              steady = 1'b0;

	// lock model state
	lock_t           held_as = LK_FREE;
	int              holders = 0;
	logic [ID_W-1:0] writer_id = '0;
	entry_t          waiters[$];

	function automatic void add_reply(status_t st, logic [ID_W-1:0] who, logic wr);
		lock_reply_t r;
		r.st = st;
		r.agent = who;
		r.wr = wr;
		r.fin = 1'b0;
		lock_replies.push_back(r);
	endfunction

	function automatic void join_waiters(logic [ID_W-1:0] who, logic wr);
		entry_t e;
		if (waiters.size() >= QUEUE_DEPTH) begin
			add_reply(ST_QUEUE_FULL, who, 1'b0);
		end else begin
			e.is_write = wr;
			e.id = who;
			waiters.push_back(e);
			add_reply(ST_QUEUED, who, wr);
		end
	endfunction

	// hand the freed lock to the head of the queue: one writer or a run of readers
	function automatic void wake_waiters(int made);
		entry_t head;
		while (waiters.size() != 0 && made < MAX_RESULTS) begin
			head = waiters[0];
			if (head.is_write) begin
				if (held_as == LK_READ)
					break;
				held_as = LK_WRITE;
				writer_id = head.id;
				waiters.delete(0);
				add_reply(ST_WAITER, head.id, 1'b1);
				break;
			end
			if (holders >= MAX_READERS)
				break;
			held_as = LK_READ;
			holders++;
			waiters.delete(0);
			add_reply(ST_WAITER, head.id, 1'b0);
			made++;
		end
	endfunction

	function automatic void apply_request(logic [1:0] md, logic [ID_W-1:0] who);
		int base;
		base = lock_replies.size();
		if (md == MODE_READ) begin
			if (held_as == LK_FREE) begin
				held_as = LK_READ;
				holders = 1;
				add_reply(ST_GRANTED, who, 1'b0);
			end else if (held_as == LK_READ && waiters.size() == 0) begin
				if (holders >= MAX_READERS) begin
					add_reply(ST_READERS_FULL, who, 1'b0);
				end else begin
					holders++;
					add_reply(ST_GRANTED, who, 1'b0);
				end
			end else begin
				join_waiters(who, 1'b0);
			end
		end else if (md == MODE_WRITE) begin
			if (held_as == LK_FREE) begin
				held_as = LK_WRITE;
				writer_id = who;
				add_reply(ST_GRANTED, who, 1'b1);
			end else begin
				join_waiters(who, 1'b1);
			end
		end else if (md == MODE_UNLOCK) begin
			if (held_as == LK_FREE) begin
				add_reply(ST_UNLOCK_FREE, who, 1'b0);
			end else if (held_as == LK_WRITE) begin
				if (who != writer_id) begin
					add_reply(ST_WRONG_WRITER, who, 1'b0);
				end else begin
					writer_id = '0;
					held_as = LK_FREE;
					add_reply(ST_RELEASED, who, 1'b0);
					wake_waiters(lock_replies.size() - base);
				end
			end else begin
				if (holders > 0)
					holders--;
				add_reply(ST_RELEASED, who, 1'b0);
				if (holders == 0) begin
					held_as = LK_FREE;
					wake_waiters(lock_replies.size() - base);
				end
			end
		end
		if (lock_replies.size() > base)
			lock_replies[$].fin = 1'b1;
	endfunction

	// driver: a word is taken when start is high and busy low at the edge
	always @(posedge clk or negedge arst_n) begin : drive
		lock_request_t req;
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_NONE;
			requester_id <= '0;
			hold_off <= 0;
		end else begin
			if (start && !busy) begin
				apply_request(mode, requester_id);
				requests_taken++;
			end
			if (start && busy) begin
				// keep presenting until taken
			end else if (hold_off != 0) begin
				start <= 1'b0;
				hold_off <= hold_off - 1;
			end else if (lock_requests.size() != 0 &&
					!(lock_requests[0].settle && lock_replies.size() != 0)) begin
				req = lock_requests.pop_front();
				start <= 1'b1;
				mode <= req.md;
				requester_id <= req.who;
				hold_off <= req.gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch
		lock_reply_t want;
		if (arst_n && result_valid) begin
			status_hits[status]++;
			if (lock_replies.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual status %0d agent %0d",
					$time, status, agent_id);
				faults++;
			end else begin
				want = lock_replies.pop_front();
				words_checked++;
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					faults++;
				end
				if (agent_id !== want.agent) begin
					$display("%0t: agent_id expected %0d actual %0d",
						$time, want.agent, agent_id);
					faults++;
				end
				if (write_grant !== want.wr) begin
					$display("%0t: write_grant expected %0b actual %0b",
						$time, want.wr, write_grant);
					faults++;
				end
				if (last !== want.fin) begin
					$display("%0t: last expected %0b actual %0b", $time, want.fin, last);
					faults++;
				end
			end
		end
	end

	task automatic queue_request(logic [1:0] md, logic [ID_W-1:0] who, bit settle = 1'b0);
		lock_request_t req;
		req.md = md;
		req.who = who;
		req.settle = settle;
		req.gap = steady ? 0 : int'($urandom_range(9, 0));
		lock_requests.push_back(req);
	endtask

	// one well-formed episode from a free lock back to a free lock
	task automatic lock_session(bit settle);
		entry_t          queued[$];
		entry_t          e;
		logic [ID_W-1:0] owner;
		bit              wr_hold;
		int              k;
		int              n;
		int              run;
		int              idx;
		wr_hold = 1'($urandom_range(1, 0));
		owner = 8'($urandom_range(255, 0));
		k = int'($urandom_range(4, 1));
		if (wr_hold) begin
			queue_request(MODE_WRITE, owner, settle);
		end else begin
			for (int i = 0; i < k; i++)
				queue_request(MODE_READ, 8'($urandom_range(255, 0)), settle && i == 0);
		end
		n = ($urandom_range(9, 0) == 0) ? QUEUE_DEPTH + 1 :
			int'($urandom_range(QUEUE_DEPTH, 0));
		for (int i = 0; i < n; i++) begin
			// behind readers only a writer makes later readers wait
			e.is_write = (!wr_hold && i == 0) ? 1'b1 : 1'($urandom_range(1, 0));
			e.id = 8'($urandom_range(255, 0));
			queue_request(e.is_write ? MODE_WRITE : MODE_READ, e.id);
			if (i < QUEUE_DEPTH)
				queued.push_back(e);
			if ($urandom_range(7, 0) == 0)
				queue_request(MODE_NONE, 8'($urandom_range(255, 0)));
			if (wr_hold && $urandom_range(7, 0) == 0)
				queue_request(MODE_UNLOCK, owner ^ 8'($urandom_range(255, 1)));
		end
		if (wr_hold) begin
			queue_request(MODE_UNLOCK, owner);
		end else begin
			for (int i = 0; i < k; i++)
				queue_request(MODE_UNLOCK, 8'($urandom_range(255, 0)));
		end
		idx = 0;
		while (idx < queued.size()) begin
			if (queued[idx].is_write) begin
				if ($urandom_range(5, 0) == 0)
					queue_request(MODE_UNLOCK, queued[idx].id ^ 8'($urandom_range(255, 1)));
				queue_request(MODE_UNLOCK, queued[idx].id);
				idx++;
			end else begin
				run = 0;
				while (idx < queued.size() && !queued[idx].is_write) begin
					run++;
					idx++;
				end
				for (int i = 0; i < run; i++)
					queue_request(MODE_UNLOCK, 8'($urandom_range(255, 0)));
			end
		end
		if ($urandom_range(3, 0) == 0)
			queue_request(MODE_UNLOCK, 8'($urandom_range(255, 0)));
	endtask

	initial begin : timeout
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : main
		int base;
		int sessions;
		foreach (status_hits[i])
			status_hits[i] = 0;

		// directed: every code, free, wrong writer, hand-over and id extremes
		queue_request(MODE_UNLOCK, 8'h00);
		queue_request(MODE_NONE, 8'hFF);
		queue_request(MODE_WRITE, 8'hA5);
		queue_request(MODE_READ, 8'h00);
		queue_request(MODE_WRITE, 8'hFF);
		queue_request(MODE_UNLOCK, 8'h5A);
		queue_request(MODE_UNLOCK, 8'hA5);
		queue_request(MODE_READ, 8'h11);
		queue_request(MODE_UNLOCK, 8'h77);
		queue_request(MODE_UNLOCK, 8'hFF);
		queue_request(MODE_UNLOCK, 8'h22);
		queue_request(MODE_READ, 8'h80);
		queue_request(MODE_READ, 8'h01);
		queue_request(MODE_WRITE, 8'h7F);
		queue_request(MODE_NONE, 8'h00);
		queue_request(MODE_UNLOCK, 8'hFE);
		queue_request(MODE_UNLOCK, 8'h01);
		queue_request(MODE_UNLOCK, 8'h7F);
		queue_request(MODE_UNLOCK, 8'h7F);

		// full queue, then one unlock that wakes sixteen readers
		queue_request(MODE_WRITE, 8'h81, 1'b1);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			queue_request(MODE_READ, 8'($urandom_range(255, 0)));
		queue_request(MODE_READ, 8'hEE);
		queue_request(MODE_WRITE, 8'h33);
		queue_request(MODE_UNLOCK, 8'h81);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			queue_request(MODE_UNLOCK, 8'($urandom_range(255, 0)));

		base = lock_requests.size();
		sessions = 0;
		while (lock_requests.size() - base < 150) begin
			steady = ($urandom_range(3, 0) == 0);
			lock_session(sessions % 8 == 0);
			sessions++;
		end

		// reader count at its ceiling, left held to the end of the run
		steady = 1'b1;
		for (int i = 0; i < MAX_READERS; i++)
			queue_request(MODE_READ, 8'(i), i == 0);
		queue_request(MODE_READ, 8'hFF);
		queue_request(MODE_WRITE, 8'hC3);
		queue_request(MODE_READ, 8'h3C);

		// unstructured tail
		steady = 1'b0;
		for (int i = 0; i < 30; i++)
			queue_request(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)), i == 0);
		requests_total = lock_requests.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (requests_taken == requests_total);
		while (lock_replies.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d requests (%0d lock sessions) and %0d words", requests_total,
			sessions, words_checked);
		$display("words by status: grant %0d queue %0d release %0d wake %0d free %0d",
			status_hits[ST_GRANTED], status_hits[ST_QUEUED], status_hits[ST_RELEASED],
			status_hits[ST_WAITER], status_hits[ST_UNLOCK_FREE]);
		$display("  wrong writer %0d queue full %0d readers full %0d",
			status_hits[ST_WRONG_WRITER], status_hits[ST_QUEUE_FULL],
			status_hits[ST_READERS_FULL]);
		if (faults == 0 && lock_replies.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
